/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Each use names the label, the
// condition or the pair of conditions, and the message. The module that
// uses them provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the first condition holds, the second holds at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the first condition holds, the second holds at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dss_pkg.sv */
`default_nettype none

package dss_pkg;

    localparam int DSS_BYTE_W = 8;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 4'd1;

    // Result kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Commands broadcast to every window cell.
    typedef struct packed {
        logic append;
        logic shift;
        logic clear;
    } dss_ctrl_t;

    // One result item.
    typedef struct packed {
        logic                  result_kind;
        logic [DSS_BYTE_W-1:0] piece_byte;
        logic                  list_done;
    } dss_res_t;

endpackage

`default_nettype wire

/* hw/rtl/dss_ifs.sv */
`default_nettype none

// Text input channel.
interface dss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       final_item;

    modport source (output valid, output text_byte, output has_byte,
                    output final_item, input ready);
    modport sink   (input valid, input text_byte, input has_byte,
                    input final_item, output ready);
endinterface

// Result output channel.
interface dss_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] piece_byte;
    logic       list_done;

    modport source (output valid, output result_kind, output piece_byte,
                    output list_done, input ready);
    modport sink   (input valid, input result_kind, input piece_byte,
                    input list_done, output ready);
endinterface

`default_nettype wire

/* hw/rtl/delimiter_string_splitter.sv */
// Channel    Dir  Payload                                   Item
// text_in    in   text_byte[7:0], has_byte, final_item      one text byte or end marker
// piece_out  out  result_kind, piece_byte[7:0], list_done   one data byte or piece end
// cfg        in   cfg_we, cfg_index[3:0], cfg_data[63:0]    one register write
//
// An item without a final mark is taken one item per cycle while text_in.ready
// is high, and gives at most one result in the cycle in which it is taken.
// A final item is followed by a flush that drains the window one byte per
// cycle while the queue has room, and ends with the marked piece end;
// text_in.ready stays low throughout the flush.
// Results pass a two-entry queue; text_in.ready depends on its fill level
// and not on piece_out.ready, so a stalled output stops the input only
// once both entries are occupied.
// rst_n clears the window, the fill count, the queue and the registers
// (delimiter bytes zero, length one) at once; there is no clearing pass.
`default_nettype none

module delimiter_string_splitter #(
    parameter int DELIMITER_MAX = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    dss_in_if.sink                              text_in,
    dss_out_if.source                           piece_out,
    input  wire logic                           cfg_we,
    input  wire logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dss_pkg::*;

`include "assert_macros.svh"

    localparam int FILL_W = $clog2(DELIMITER_MAX + 1);

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic [FILL_W-1:0]     fill_inc;
    logic [CFG_DATA_W-1:0] delim_bytes_reg;
    logic [CFG_DATA_W-1:0] delim_bytes_next;
    logic [LEN_W-1:0]      delim_len_reg;
    logic [LEN_W-1:0]      delim_len_next;
    logic [LEN_W-1:0]      len_eff;

    dss_ctrl_t             ctrl;
    logic [DSS_BYTE_W-1:0] cur_bytes [DELIMITER_MAX];
    logic [DELIMITER_MAX-1:0] match_ok;
    logic                  accept;
    logic                  push;
    dss_res_t              push_item;
    logic                  q_full;

    // A length of zero acts as one; a length beyond the window saturates.
    always_comb
    begin
        if (delim_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (delim_len_reg > LEN_W'(DELIMITER_MAX))
        begin
            len_eff = LEN_W'(DELIMITER_MAX);
        end
        else
        begin
            len_eff = delim_len_reg;
        end
    end

    assign text_in.ready = (state_reg == ST_RUN) && !q_full;
    assign accept        = text_in.valid && text_in.ready;
    assign fill_inc      = fill_reg + FILL_W'(1);

    // The window is a row of cells. Entry 0 holds the oldest byte; a new
    // byte goes into the cell at the fill position, and a shift moves every
    // byte one cell toward entry 0.
    for (genvar i = 0; i < DELIMITER_MAX; i++)
    begin : g_win
        logic [DSS_BYTE_W-1:0] right;

        if (i == DELIMITER_MAX - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_mid
            assign right = cur_bytes[i+1];
        end

        dss_cell u_win_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sel        (fill_reg == FILL_W'(i)),
            .in_byte    (text_in.text_byte),
            .delim_byte (delim_bytes_reg[DSS_BYTE_W*i +: DSS_BYTE_W]),
            .in_use     (LEN_W'(i) < len_eff),
            .right_byte (right),
            .cur_byte   (cur_bytes[i]),
            .match_ok   (match_ok[i])
        );
    end

    // Window control. A byte that fills the window either closes a piece
    // (the whole window equals the delimiter) or pushes out the oldest byte
    // as data. A final item switches to the flush, which drains the held
    // bytes and then gives the piece end that closes the text.
    always_comb
    begin
        ctrl       = '0;
        push       = 1'b0;
        push_item  = '{result_kind: KIND_DATA, piece_byte: cur_bytes[0], list_done: 1'b0};
        fill_next  = fill_reg;
        state_next = state_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (text_in.has_byte)
                    begin
                        ctrl.append = 1'b1;
                        if (LEN_W'(fill_inc) == len_eff)
                        begin
                            push = 1'b1;
                            if (&match_ok)
                            begin
                                push_item.result_kind = KIND_END;
                                push_item.piece_byte  = '0;
                                ctrl.clear            = 1'b1;
                                fill_next             = '0;
                            end
                            else
                            begin
                                // The new byte takes the place of the oldest one.
                                ctrl.shift = 1'b1;
                            end
                        end
                        else
                        begin
                            fill_next = fill_inc;
                        end
                    end
                    if (text_in.final_item)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!q_full)
                begin
                    push = 1'b1;
                    if (fill_reg != '0)
                    begin
                        ctrl.shift = 1'b1;
                        fill_next  = fill_reg - FILL_W'(1);
                    end
                    else
                    begin
                        push_item.result_kind = KIND_END;
                        push_item.piece_byte  = '0;
                        push_item.list_done   = 1'b1;
                        state_next            = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        // A new length drops whatever the window holds.
        if (cfg_we && (cfg_index == CFG_DELIM_LENGTH))
        begin
            ctrl.clear = 1'b1;
            fill_next  = '0;
        end
    end

    always_comb
    begin
        delim_bytes_next = delim_bytes_reg;
        delim_len_next   = delim_len_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELIM_BYTES:  delim_bytes_next = cfg_data;
                CFG_DELIM_LENGTH: delim_len_next   = cfg_data[LEN_W-1:0];
                default:          delim_len_next   = delim_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            fill_reg        <= '0;
            delim_bytes_reg <= '0;
            delim_len_reg   <= LEN_W'(1);
        end
        else
        begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            delim_bytes_reg <= delim_bytes_next;
            delim_len_reg   <= delim_len_next;
        end
    end

    dss_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .res_out   (piece_out)
    );

    // Between items the window never holds a full delimiter length.
    `ASSERT_ALWAYS(a_fill_below_len, LEN_W'(fill_reg) < len_eff, "window fill reached delimiter length")

    // A result is only produced when the queue has room for it.
    `ASSERT_IMPLIES(a_push_has_room, push, !q_full, "result pushed into a full queue")

    // An accepted final item always starts the flush.
    `ASSERT_NEXT(a_final_flush, accept && text_in.final_item, state_reg == ST_FLUSH, "final item did not start the flush")

endmodule

`default_nettype wire

/* hw/rtl/dss_cell.sv */
`default_nettype none

// One byte of the match window. It can take the incoming byte, compare
// against its delimiter byte, and take the byte of its right neighbor on a shift.
module dss_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dss_pkg::dss_ctrl_t             ctrl,
    input  wire logic                           sel,
    input  wire logic [dss_pkg::DSS_BYTE_W-1:0] in_byte,
    input  wire logic [dss_pkg::DSS_BYTE_W-1:0] delim_byte,
    input  wire logic                           in_use,
    input  wire logic [dss_pkg::DSS_BYTE_W-1:0] right_byte,
    output logic      [dss_pkg::DSS_BYTE_W-1:0] cur_byte,
    output logic                                match_ok
);
    import dss_pkg::*;

    logic [DSS_BYTE_W-1:0] byte_reg;
    logic [DSS_BYTE_W-1:0] byte_next;

    // Value after the incoming byte has been written, seen by the compare
    // and by the left neighbor.
    assign cur_byte = (ctrl.append && sel) ? in_byte : byte_reg;
    assign match_ok = !in_use || (cur_byte == delim_byte);

    always_comb
    begin
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.shift)
        begin
            byte_next = right_byte;
        end
        else
        begin
            byte_next = cur_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dss_outq.sv */
`default_nettype none

// Two-entry result queue; its fill level alone decides whether a new
// result can be taken, so the input side never waits on the output ready.
module dss_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dss_pkg::dss_res_t push_item,
    output logic                   full,
    dss_out_if.source              res_out
);
    import dss_pkg::*;

    localparam int QDEPTH = 2;

    dss_res_t   slot_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;
    dss_res_t   head;

    assign head                = slot_reg[rd_ptr_reg];
    assign res_out.valid       = (count_reg != 2'd0);
    assign res_out.result_kind = head.result_kind;
    assign res_out.piece_byte  = head.piece_byte;
    assign res_out.list_done   = head.list_done;
    assign full                = (count_reg == 2'(QDEPTH));
    assign pop                 = res_out.valid && res_out.ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire
